// ===== design/wpp_pkg.sv =====
// shared types and constants for the wav pcm stream parser
package wpp_pkg;
	localparam int CfgW = 32;
	localparam int QueueDepth = 4;

	localparam logic [3:0] PH_RIFF  = 4'd0;
	localparam logic [3:0] PH_RSIZE = 4'd1;
	localparam logic [3:0] PH_WAVE  = 4'd2;
	localparam logic [3:0] PH_ID    = 4'd3;
	localparam logic [3:0] PH_SIZE  = 4'd4;
	localparam logic [3:0] PH_BODY  = 4'd5;
	localparam logic [3:0] PH_PAD   = 4'd6;
	localparam logic [3:0] PH_ERR   = 4'd7;

	localparam logic [1:0] CK_FMT  = 2'd0;
	localparam logic [1:0] CK_DATA = 2'd1;
	localparam logic [1:0] CK_SKIP = 2'd2;

	localparam logic [1:0] KIND_SAMPLE = 2'd0;
	localparam logic [1:0] KIND_OK     = 2'd1;
	localparam logic [1:0] KIND_ERR    = 2'd2;

	localparam logic [3:0] ERR_NONE      = 4'd0;
	localparam logic [3:0] ERR_NO_RIFF   = 4'd1;
	localparam logic [3:0] ERR_SIZE      = 4'd2;
	localparam logic [3:0] ERR_NOT_WAVE  = 4'd3;
	localparam logic [3:0] ERR_EXTRA     = 4'd4;
	localparam logic [3:0] ERR_FMT_SMALL = 4'd5;
	localparam logic [3:0] ERR_FLOAT     = 4'd6;
	localparam logic [3:0] ERR_ALAW      = 4'd7;
	localparam logic [3:0] ERR_MULAW     = 4'd8;
	localparam logic [3:0] ERR_EXT       = 4'd9;
	localparam logic [3:0] ERR_CHANNELS  = 4'd10;
	localparam logic [3:0] ERR_BITS      = 4'd11;
	localparam logic [3:0] ERR_TRUNC     = 4'd12;

	localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
	localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
	localparam logic [31:0] TAG_FMT  = 32'h2074_6D66;
	localparam logic [31:0] TAG_DATA = 32'h6174_6164;

	// classified word from the front part to the back part
	typedef struct packed {
		logic        has_sample;
		logic [15:0] sample;
		logic        chan;
		logic        has_status;
		logic [3:0]  code;
	} wpp_cmd_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [18:0] sample_value;
		logic        channel;
		logic [3:0]  error_code;
		logic        last_of_run;
	} wpp_res_t;
endpackage

// ===== design/wpp_front.sv =====
// header walker and chunk classifier, one byte per cycle while the queue has room
module wpp_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic [31:0]          file_length,
	input  logic                 in_valid,
	input  logic [7:0]           in_byte,
	input  logic                 in_eof,
	output logic                 in_ready,
	output wpp_pkg::wpp_cmd_t    cmd,
	output logic                 cmd_valid,
	input  logic                 cmd_ready
);
	import wpp_pkg::*;

	logic [3:0]  phase_q;
	logic [31:0] pos_q, shift_q, remain_q;
	logic [1:0]  ck_q;
	logic [15:0] tag_q, chans_q, bits_q;
	logic [7:0]  low_q;
	logic        tog_q, seen_q, pad_q;
	logic [3:0]  err_q;

	logic [3:0]  phase_n;
	logic [31:0] pos_n, shift_n, remain_n;
	logic [1:0]  ck_n;
	logic [15:0] tag_n, chans_n, bits_n;
	logic [7:0]  low_n;
	logic        tog_n, seen_n, pad_n;
	logic [3:0]  err_n;
	logic [31:0] fs;
	logic        fire;
	wpp_cmd_t    c;

	assign in_ready = cmd_ready;
	assign fire = in_valid && in_ready;
	assign fs = {in_byte, shift_q[31:8]};

	always_comb begin
		phase_n = phase_q; pos_n = pos_q; shift_n = shift_q; remain_n = remain_q;
		ck_n = ck_q; tag_n = tag_q; chans_n = chans_q; bits_n = bits_q;
		low_n = low_q; tog_n = tog_q; seen_n = seen_q; pad_n = pad_q; err_n = err_q;
		c = '0;
		unique case (phase_q)
			PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
				shift_n = fs;
				pos_n = pos_q + 32'd1;
				if (pos_q[1:0] == 2'd3) begin
					pos_n = '0;
					unique case (phase_q)
						PH_RIFF: begin
							if (fs != TAG_RIFF) begin err_n = ERR_NO_RIFF; phase_n = PH_ERR; end
							else phase_n = PH_RSIZE;
						end
						PH_RSIZE: begin
							if (fs + 32'd8 != file_length) begin
								err_n = ERR_SIZE; phase_n = PH_ERR;
							end else phase_n = PH_WAVE;
						end
						PH_WAVE: begin
							if (fs != TAG_WAVE) begin err_n = ERR_NOT_WAVE; phase_n = PH_ERR; end
							else phase_n = PH_ID;
						end
						PH_ID: begin
							if (fs == TAG_RIFF) begin
								err_n = ERR_EXTRA; phase_n = PH_ERR;
							end else begin
								if (fs == TAG_FMT) ck_n = CK_FMT;
								else if (fs == TAG_DATA) ck_n = CK_DATA;
								else ck_n = CK_SKIP;
								phase_n = PH_SIZE;
							end
						end
						default: begin
							if (ck_q == CK_FMT && fs < 32'd16) begin
								err_n = ERR_FMT_SMALL; phase_n = PH_ERR;
							end else begin
								if (ck_q == CK_DATA) begin
									if (seen_q) ck_n = CK_SKIP;
									seen_n = 1'b1;
									tog_n = 1'b0;
								end
								remain_n = fs;
								pad_n = fs[0];
								if (fs == '0) begin
									phase_n = fs[0] ? PH_PAD : PH_ID;
									shift_n = '0;
								end else begin
									phase_n = PH_BODY;
									shift_n = '0;
								end
							end
						end
					endcase
				end
			end
			PH_BODY: begin
				if (ck_q == CK_FMT) begin
					case (pos_q[3:0])
						4'd0:  if (pos_q[31:4] == '0) tag_n[7:0] = in_byte;
						4'd1:  if (pos_q[31:4] == '0) tag_n[15:8] = in_byte;
						4'd2:  if (pos_q[31:4] == '0) chans_n[7:0] = in_byte;
						4'd3:  if (pos_q[31:4] == '0) chans_n[15:8] = in_byte;
						4'd14: if (pos_q[31:4] == '0) bits_n[7:0] = in_byte;
						4'd15: if (pos_q[31:4] == '0) bits_n[15:8] = in_byte;
						default: ;
					endcase
				end else if (ck_q == CK_DATA) begin
					if (!pos_q[0]) low_n = in_byte;
					else begin
						c.has_sample = 1'b1;
						c.sample = {in_byte, low_q};
						c.chan = tog_q;
						tog_n = ~tog_q;
					end
				end
				pos_n = pos_q + 32'd1;
				remain_n = remain_q - 32'd1;
				if (ck_q == CK_FMT && pos_q == 32'd15) begin
					if (tag_q == 16'h0003) begin err_n = ERR_FLOAT; phase_n = PH_ERR; end
					else if (tag_q == 16'h0006) begin err_n = ERR_ALAW; phase_n = PH_ERR; end
					else if (tag_q == 16'h0007) begin err_n = ERR_MULAW; phase_n = PH_ERR; end
					else if (tag_q == 16'hFFFE) begin err_n = ERR_EXT; phase_n = PH_ERR; end
					else if (chans_q != 16'd2) begin err_n = ERR_CHANNELS; phase_n = PH_ERR; end
					else if (bits_n != 16'd16) begin err_n = ERR_BITS; phase_n = PH_ERR; end
				end
				if (phase_n != PH_ERR && remain_n == '0) begin
					phase_n = pad_q ? PH_PAD : PH_ID;
					pos_n = '0;
					shift_n = '0;
				end
			end
			PH_PAD: begin
				pad_n = 1'b0; phase_n = PH_ID; pos_n = '0; shift_n = '0;
			end
			default: ;
		endcase
		if (in_eof) begin
			c.has_status = 1'b1;
			c.code = err_n;
			if (err_n == ERR_NONE &&
			    !((phase_n == PH_ID && pos_n == '0) || phase_n == PH_PAD))
				c.code = ERR_TRUNC;
			phase_n = PH_RIFF; pos_n = '0; shift_n = '0; remain_n = '0; ck_n = CK_FMT;
			tag_n = '0; chans_n = '0; bits_n = '0; low_n = '0; tog_n = 1'b0;
			seen_n = 1'b0; pad_n = 1'b0; err_n = ERR_NONE;
		end
	end

	assign cmd = c;
	assign cmd_valid = fire && (c.has_sample || c.has_status);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_RIFF; pos_q <= '0; shift_q <= '0; remain_q <= '0; ck_q <= CK_FMT;
			tag_q <= '0; chans_q <= '0; bits_q <= '0; low_q <= '0; tog_q <= 1'b0;
			seen_q <= 1'b0; pad_q <= 1'b0; err_q <= ERR_NONE;
		end else if (fire) begin
			phase_q <= phase_n; pos_q <= pos_n; shift_q <= shift_n; remain_q <= remain_n;
			ck_q <= ck_n; tag_q <= tag_n; chans_q <= chans_n; bits_q <= bits_n;
			low_q <= low_n; tog_q <= tog_n; seen_q <= seen_n; pad_q <= pad_n; err_q <= err_n;
		end
	end
endmodule

// ===== design/wpp_queue.sv =====
// small word queue between the front and back parts
module wpp_queue #(
	parameter int Depth = wpp_pkg::QueueDepth
) (
	input  logic               clk,
	input  logic               arst_n,
	input  wpp_pkg::wpp_cmd_t  wr_data,
	input  logic               wr_valid,
	output logic               wr_ready,
	output wpp_pkg::wpp_cmd_t  rd_data,
	output logic               rd_valid,
	input  logic               rd_ready
);
	import wpp_pkg::*;
	localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

	wpp_cmd_t mem_q [Depth];
	logic [AW-1:0] wp_q, rp_q;
	logic [AW:0]   cnt_q;
	logic wr, rd;

	assign wr_ready = cnt_q != (AW+1)'(Depth);
	assign rd_valid = cnt_q != '0;
	assign rd_data = mem_q[rp_q];
	assign wr = wr_valid && wr_ready;
	assign rd = rd_valid && rd_ready;

	always_ff @(posedge clk) begin
		if (wr) mem_q[wp_q] <= wr_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0; rp_q <= '0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= (wp_q == AW'(Depth-1)) ? '0 : wp_q + 1'b1;
			if (rd) rp_q <= (rp_q == AW'(Depth-1)) ? '0 : rp_q + 1'b1;
			cnt_q <= cnt_q + (AW+1)'(wr) - (AW+1)'(rd);
		end
	end
endmodule

// ===== design/wpp_back.sv =====
// sample scaling and result sequencing, up to two results per word
module wpp_back (
	input  logic               clk,
	input  logic               arst_n,
	input  wpp_pkg::wpp_cmd_t  cmd,
	input  logic               cmd_valid,
	output logic               cmd_ready,
	output wpp_pkg::wpp_res_t  res,
	output logic               res_valid,
	input  logic               res_ready
);
	import wpp_pkg::*;

	// m*2^17/65535 = 2m + 2m/65535 with m = |2s+1| <= 65535, so the rounded tail is 0, 1 or 2
	logic signed [16:0] twos;
	logic [16:0] m;
	logic [1:0]  corr;
	logic [17:0] q;
	logic [18:0] sval;
	logic        second_q;
	wpp_res_t    r;
	logic        out_en;

	assign twos = {cmd.sample, 1'b1};
	assign m = twos[16] ? 17'(-twos) : 17'(twos);
	assign corr = (m >= 17'd49152) ? 2'd2 : ((m >= 17'd16384) ? 2'd1 : 2'd0);
	assign q = {m, 1'b0} + 18'(corr);
	assign sval = twos[16] ? 19'(-{1'b0, q}) : {1'b0, q};

	always_comb begin
		r = '0;
		if (cmd.has_sample && !second_q) begin
			r.kind = KIND_SAMPLE;
			r.sample_value = sval;
			r.channel = cmd.chan;
			r.last_of_run = !cmd.has_status;
		end else begin
			r.kind = (cmd.code == ERR_NONE) ? KIND_OK : KIND_ERR;
			r.error_code = cmd.code;
			r.last_of_run = 1'b1;
		end
	end

	assign out_en = cmd_valid && (!res_valid || res_ready);
	assign cmd_ready = out_en && r.last_of_run;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid <= 1'b0;
			second_q <= 1'b0;
		end else begin
			if (out_en) res_valid <= 1'b1;
			else if (res_ready) res_valid <= 1'b0;
			if (out_en) second_q <= !r.last_of_run;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) res <= r;
	end
endmodule

// ===== design/wav_pcm_stream_parser.sv =====
// top level of the wav pcm stream parser
// ordering: a sample or status passes through the queue and the back part's result register; a
// status that follows a sample of the same byte comes after that sample
// throughput: one byte per cycle while the queue has room; a byte that yields sample and status
// holds the back part for both results, absorbed by the four-word queue
// reset: arst_n clears parse state, queue pointers and output valid; file_length resets to zero
module wav_pcm_stream_parser #(
	parameter int QueueDepth = wpp_pkg::QueueDepth
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [7:0]  s_tdata,   // in_byte
	input  logic        s_tlast,   // end_of_file
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata,   // sample_value[18:0], channel[19], error_code[23:20]
	output logic [1:0]  m_tuser,   // kind
	output logic        m_tlast    // last_of_run
);
	import wpp_pkg::*;

	logic [31:0] file_length_q;
	wpp_cmd_t fcmd, qcmd;
	logic fv, fr, qv, qr;
	wpp_res_t res;

	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) file_length_q <= '0;
		else if (cfg_valid) file_length_q <= cfg_data;
	end

	wpp_front u_front (
		.clk, .arst_n, .file_length(file_length_q),
		.in_valid(s_tvalid), .in_byte(s_tdata), .in_eof(s_tlast), .in_ready(s_tready),
		.cmd(fcmd), .cmd_valid(fv), .cmd_ready(fr)
	);

	wpp_queue #(.Depth(QueueDepth)) u_queue (
		.clk, .arst_n, .wr_data(fcmd), .wr_valid(fv), .wr_ready(fr),
		.rd_data(qcmd), .rd_valid(qv), .rd_ready(qr)
	);

	wpp_back u_back (
		.clk, .arst_n, .cmd(qcmd), .cmd_valid(qv), .cmd_ready(qr),
		.res(res), .res_valid(m_tvalid), .res_ready(m_tready)
	);

	assign m_tdata = {res.error_code, res.channel, res.sample_value};
	assign m_tuser = res.kind;
	assign m_tlast = res.last_of_run;

`ifndef ASSERT_OFF
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
			&& $stable(m_tlast))
		else $error("result changed while stalled");
	a_ok_code: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == KIND_OK |-> m_tdata[23:20] == ERR_NONE && m_tlast)
		else $error("ok status with error code");
	a_no_drop: assert property (@(posedge clk) disable iff (!arst_n)
		fv |-> fr)
		else $error("front word lost");
`endif
endmodule

// ===== sim/testbench.sv =====
// testbench for the wav pcm stream parser: byte stimulus, predicted samples and status words
module testbench;
	import wpp_pkg::*;

	typedef struct {
		logic [7:0] b;
		logic       eof;
	} byte_item_t;

	typedef struct {
		logic [1:0]  kind;
		logic [18:0] value;
		logic        chan;
		logic [3:0]  code;
		logic        last;
	} wav_word_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata = '0;
	logic        s_tlast = 1'b0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic [1:0]  m_tuser;
	logic        m_tlast;

	wav_pcm_stream_parser u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	always #1 clk = ~clk;

	byte_item_t  pending_bytes[$];
	wav_word_t   expected_words[$];
	int          mismatches = 0;
	int          words_seen = 0;
	int          files_sent = 0;
	longint      cycle_count = 0;
	int          send_gap = 0;
	int          recv_gap = 0;
	int          recv_hold = 0;
	bit          stim_done = 1'b0;

	// predictor state
	logic [31:0] p_len;
	logic [3:0]  p_phase;
	logic [31:0] p_pos, p_shift, p_remain;
	logic [1:0]  p_ck;
	logic [15:0] p_tag, p_chans, p_bits;
	logic [7:0]  p_low;
	logic        p_tog, p_seen, p_pad;
	logic [3:0]  p_err;

	task automatic clear_parser();
		p_phase = PH_RIFF; p_pos = 0; p_shift = 0; p_remain = 0; p_ck = CK_FMT;
		p_tag = 0; p_chans = 0; p_bits = 0; p_low = 0; p_tog = 0; p_seen = 0;
		p_pad = 0; p_err = ERR_NONE;
	endtask

	task automatic latch_error(input logic [3:0] c);
		p_err = c; p_phase = PH_ERR;
	endtask

	function automatic logic [18:0] sample_q17(input logic [7:0] lo, input logic [7:0] hi);
		longint s, n, m, q;
		s = $signed({hi, lo});
		n = (2 * s + 1) * 131072;
		m = n < 0 ? -n : n;
		q = (m + 32767) / 65535;
		q = n < 0 ? -q : q;
		return q[18:0];
	endfunction

	task automatic finish_body();
		p_phase = p_pad ? PH_PAD : PH_ID; p_pos = 0; p_shift = 0;
	endtask

	task automatic predict_byte(input logic [7:0] b, input logic eof);
		wav_word_t w;
		int n0;
		logic [3:0] c;
		logic [31:0] pos;
		n0 = expected_words.size();
		case (p_phase)
			PH_RIFF, PH_RSIZE, PH_WAVE, PH_ID, PH_SIZE: begin
				p_shift = {b, p_shift[31:8]};
				p_pos++;
				if (p_pos >= 4) begin
					p_pos = 0;
					if (p_phase == PH_RIFF) begin
						if (p_shift != TAG_RIFF) latch_error(ERR_NO_RIFF); else p_phase = PH_RSIZE;
					end else if (p_phase == PH_RSIZE) begin
						if (p_shift + 32'd8 != p_len) latch_error(ERR_SIZE); else p_phase = PH_WAVE;
					end else if (p_phase == PH_WAVE) begin
						if (p_shift != TAG_WAVE) latch_error(ERR_NOT_WAVE); else p_phase = PH_ID;
					end else if (p_phase == PH_ID) begin
						if (p_shift == TAG_RIFF) latch_error(ERR_EXTRA);
						else begin
							p_ck = p_shift == TAG_FMT ? CK_FMT : p_shift == TAG_DATA ? CK_DATA : CK_SKIP;
							p_phase = PH_SIZE;
						end
					end else begin
						if (p_ck == CK_FMT && p_shift < 16) latch_error(ERR_FMT_SMALL);
						else begin
							if (p_ck == CK_DATA) begin
								if (p_seen) p_ck = CK_SKIP;
								p_seen = 1; p_tog = 0;
							end
							p_remain = p_shift; p_pad = p_shift[0];
							if (p_shift == 0) finish_body();
							else begin
								p_phase = PH_BODY; p_shift = 0;
							end
						end
					end
				end
			end
			PH_BODY: begin
				pos = p_pos;
				if (p_ck == CK_FMT) begin
					case (pos)
						0: p_tag[7:0] = b;
						1: p_tag[15:8] = b;
						2: p_chans[7:0] = b;
						3: p_chans[15:8] = b;
						14: p_bits[7:0] = b;
						15: p_bits[15:8] = b;
						default: ;
					endcase
				end else if (p_ck == CK_DATA) begin
					if (!pos[0]) p_low = b;
					else begin
						w = '{KIND_SAMPLE, sample_q17(p_low, b), p_tog, ERR_NONE, 1'b0};
						expected_words.push_back(w);
						p_tog = ~p_tog;
					end
				end
				p_pos = pos + 1;
				p_remain--;
				if (p_ck == CK_FMT && pos == 15) begin
					if (p_tag == 16'h0003) latch_error(ERR_FLOAT);
					else if (p_tag == 16'h0006) latch_error(ERR_ALAW);
					else if (p_tag == 16'h0007) latch_error(ERR_MULAW);
					else if (p_tag == 16'hFFFE) latch_error(ERR_EXT);
					else if (p_chans != 2) latch_error(ERR_CHANNELS);
					else if (p_bits != 16) latch_error(ERR_BITS);
				end
				if (p_phase != PH_ERR && p_remain == 0) finish_body();
			end
			PH_PAD: begin
				p_pad = 0; p_phase = PH_ID; p_pos = 0; p_shift = 0;
			end
			default: ;
		endcase
		if (eof) begin
			c = p_err;
			if (c == ERR_NONE && !((p_phase == PH_ID && p_pos == 0) || p_phase == PH_PAD))
				c = ERR_TRUNC;
			w = '{c != ERR_NONE ? KIND_ERR : KIND_OK, 19'd0, 1'b0, c, 1'b0};
			expected_words.push_back(w);
			clear_parser();
		end
		if (expected_words.size() > n0) expected_words[expected_words.size() - 1].last = 1'b1;
	endtask

	// stimulus building
	logic [7:0] fbuf[$];

	task automatic put32(input logic [31:0] v);
		for (int i = 0; i < 4; i++) fbuf.push_back(v[8*i +: 8]);
	endtask

	task automatic put_fmt(input logic [15:0] tag, input logic [15:0] ch,
			input logic [15:0] bits, input int extra);
		put32(TAG_FMT); put32(16 + extra);
		fbuf.push_back(tag[7:0]); fbuf.push_back(tag[15:8]);
		fbuf.push_back(ch[7:0]); fbuf.push_back(ch[15:8]);
		for (int i = 0; i < 10; i++) fbuf.push_back(8'($urandom_range(0, 255)));
		fbuf.push_back(bits[7:0]); fbuf.push_back(bits[15:8]);
		for (int i = 0; i < extra; i++) fbuf.push_back(8'($urandom_range(0, 255)));
		if (extra % 2) fbuf.push_back(8'h00);
	endtask

	task automatic put_chunk(input logic [31:0] id, input int n);
		put32(id); put32(n);
		for (int i = 0; i < n; i++) fbuf.push_back(8'($urandom_range(0, 255)));
		if (n % 2) fbuf.push_back(8'($urandom_range(0, 255)));
	endtask

	// queue bytes of fbuf as one file, last byte flagged; cut keeps only first bytes
	task automatic queue_file(input int cut);
		byte_item_t it;
		int n;
		n = (cut > 0 && cut < fbuf.size()) ? cut : fbuf.size();
		for (int i = 0; i < n; i++) begin
			it.b = fbuf[i]; it.eof = (i == n - 1);
			pending_bytes.push_back(it);
		end
		fbuf.delete();
		files_sent++;
	endtask

	// build a well formed-ish file: header with a zero size field, then random chunks
	task automatic build_random_file();
		int k, pick;
		put32(TAG_RIFF); put32(0); put32(TAG_WAVE);
		k = $urandom_range(1, 3);
		for (int i = 0; i < k; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 3) put_fmt(16'h0001, 16'd2, 16'd16, $urandom_range(0, 3));
			else if (pick == 3)
				put_fmt($urandom_range(0, 1) ? 16'h0003 : 16'($urandom_range(0, 65535)),
					16'($urandom_range(1, 3)),
					$urandom_range(0, 1) ? 16'd16 : 16'($urandom_range(0, 65535)), 0);
			else if (pick < 8) put_chunk(TAG_DATA, $urandom_range(0, 24));
			else put_chunk($urandom(), $urandom_range(0, 5));
		end
	endtask

	task automatic set_length(input logic [31:0] v);
		@(posedge clk);
		cfg_valid <= 1'b1; cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		p_len = v;
	endtask

	task automatic wait_drained();
		while (pending_bytes.size() > 0 || s_tvalid || expected_words.size() > 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// sender
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) begin
				predict_byte(s_tdata, s_tlast);
				send_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
			end
			if ((!s_tvalid || s_tready) && send_gap > 0) begin
				send_gap--;
				s_tvalid <= 1'b0;
			end else if ((!s_tvalid || s_tready) && pending_bytes.size() > 0) begin
				s_tvalid <= 1'b1;
				s_tdata <= pending_bytes[0].b;
				s_tlast <= pending_bytes[0].eof;
				void'(pending_bytes.pop_front());
			end else if (s_tready) begin
				s_tvalid <= 1'b0;
			end
		end
	end

	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		mismatches++;
		$display("mismatch at word %0d: %s got %0h want %0h", words_seen, what, got, want);
	endtask

	// receiver
	always @(posedge clk) begin
		wav_word_t w;
		cycle_count++;
		if (arst_n) begin
			if (m_tvalid && m_tready) begin
				if (expected_words.size() == 0) report("unexpected word", 32'(m_tdata), 32'd0);
				else begin
					w = expected_words.pop_front();
					if (m_tuser != w.kind) report("kind", 32'(m_tuser), 32'(w.kind));
					if (m_tdata[18:0] != w.value)
						report("sample", 32'(m_tdata[18:0]), 32'(w.value));
					if (m_tdata[19] != w.chan) report("channel", 32'(m_tdata[19]), 32'(w.chan));
					if (m_tdata[23:20] != w.code)
						report("error code", 32'(m_tdata[23:20]), 32'(w.code));
					if (m_tlast != w.last) report("last", 32'(m_tlast), 32'(w.last));
				end
				words_seen++;
				recv_gap = $urandom_range(0, 3) == 0 ? $urandom_range(0, 15) : 0;
			end
			if (recv_hold > 0) begin
				recv_hold--;
				m_tready <= 1'b0;
			end else if (recv_gap > 0) begin
				recv_gap--;
				m_tready <= 1'b0;
			end else m_tready <= 1'b1;
		end
		if (cycle_count > 2000000) begin
			$display("FAILURE");
			$finish;
		end
	end

	initial begin
		clear_parser();
		p_len = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// reset length zero: bad tag, then a header whose size matches 0 with wrap
		fbuf.push_back(8'h00); fbuf.push_back(8'hFF); fbuf.push_back(8'h52); fbuf.push_back(8'h49);
		queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF8); put32(TAG_WAVE); queue_file(0);
		wait_drained();

		set_length(32'hFFFF_FFFF);
		put32(TAG_RIFF); put32(32'd5); queue_file(0);          // size mismatch
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(32'h0); queue_file(0);  // not wave
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE); put32(TAG_RIFF); queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE); put32(TAG_FMT); put32(15);
		queue_file(0);
		foreach (fbuf[i]) ;
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put_fmt(16'h0006, 2, 16, 0); queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put_fmt(16'h0007, 2, 16, 0); queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put_fmt(16'hFFFE, 2, 16, 0); queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put_fmt(16'h0001, 1, 16, 0); queue_file(0);
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put_fmt(16'h0001, 2, 8, 0); queue_file(0);
		// missing fmt, extreme samples, odd size pad, second data skipped, unknown chunk
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE);
		put32(TAG_DATA); put32(9);
		fbuf.push_back(8'h00); fbuf.push_back(8'h80); fbuf.push_back(8'hFF); fbuf.push_back(8'h7F);
		fbuf.push_back(8'hFF); fbuf.push_back(8'hFF); fbuf.push_back(8'h00); fbuf.push_back(8'h00);
		fbuf.push_back(8'h11); fbuf.push_back(8'h00);
		put_chunk(32'h5453_494C, 3); put_chunk(TAG_DATA, 4);
		queue_file(0);
		// file cut inside the data chunk's size field: truncated status only
		put32(TAG_RIFF); put32(32'hFFFF_FFF7); put32(TAG_WAVE); put_chunk(TAG_DATA, 6);
		queue_file(18);
		wait_drained();

		// random files under several lengths; most files carry a matching length
		for (int f = 0; f < 15; f++) begin
			int len;
			build_random_file();
			len = fbuf.size();
			if ($urandom_range(0, 7) == 0) len = len + $urandom_range(1, 3);
			{fbuf[7], fbuf[6], fbuf[5], fbuf[4]} = len - 8;
			if ($urandom_range(0, 9) == 0) fbuf[$urandom_range(0, fbuf.size() - 1)] = 8'($urandom());
			if (f % 6 == 0) begin
				wait_drained();
				set_length(len);
			end else if (p_len != len) begin
				{fbuf[7], fbuf[6], fbuf[5], fbuf[4]} = p_len - 8;
			end
			queue_file($urandom_range(0, 5) == 0 ? $urandom_range(1, fbuf.size()) : 0);
			if (f == 11) begin
				// long receiver hold while bytes of several files are pending, so the queue fills and input stalls
				recv_hold = 300;
				wait_drained();
			end
		end
		// plain noise bytes
		for (int i = 0; i < 40; i++) fbuf.push_back(8'($urandom()));
		queue_file(0);
		wait_drained();
		set_length(32'd0);
		wait_drained();

		$display("covered %0d files and %0d output words, header, fmt, data and skip paths",
			files_sent, words_seen);
		if (mismatches == 0) $display("SUCCESS");
		else $display("FAILURE");
		$finish;
	end
endmodule
